// ----- sv/drlm_pkg.sv -----
// Shared constants, types and helpers for the dirty rectangle list merger.
// Used by every module of the block; depends on nothing else.
package drlm_pkg;

  localparam int MAX_RECTS  = 16;
  localparam int COORD_BITS = 12;
  localparam int CAP_W      = 5;
  localparam int TOTAL_W    = 5;
  localparam int CNT_W      = $clog2(MAX_RECTS + 1);
  localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int DIM_W      = COORD_BITS + 1;
  localparam int AREA_W     = 2 * COORD_BITS + 1;
  localparam int SUM_W      = AREA_W + 2;

  // Request operation codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [AREA_W-1:0]     area_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Inclusive rectangle corners.
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } box_t;

  // One stored list entry with its pixel count kept alongside.
  typedef struct packed {
    box_t  box;
    area_t area;
  } entry_t;

  // Result of comparing the growing rectangle against one entry.
  typedef struct packed {
    box_t  jbox;
    area_t jarea;
    area_t com;
    area_t sarea;
  } eval_t;

  // Bounding box of two rectangles.
  function automatic box_t box_join(box_t a, box_t b);
    box_t r;
    r    = a;
    r.x1 = (b.x1 < a.x1) ? b.x1 : a.x1;
    r.y1 = (b.y1 < a.y1) ? b.y1 : a.y1;
    r.x2 = (b.x2 > a.x2) ? b.x2 : a.x2;
    r.y2 = (b.y2 > a.y2) ? b.y2 : a.y2;
    return r;
  endfunction

  // Inclusive span between two coordinates.
  function automatic dim_t span(coord_t lo, coord_t hi);
    return {1'b0, hi} - {1'b0, lo} + dim_t'(1);
  endfunction

endpackage

// ----- sv/drlm_cell.sv -----
// One storage cell of the rectangle chain.
// Loads a new entry or takes its right neighbor's entry; uses drlm_pkg.
module drlm_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  logic            wr_en,
  input  drlm_pkg::entry_t nb_in,
  input  drlm_pkg::entry_t wr_data,
  output drlm_pkg::entry_t q
);
  import drlm_pkg::*;

  entry_t q_r;

  // A direct write wins over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r <= wr_data;
    end else if (shift_en) begin
      q_r <= nb_in;
    end
  end

  assign q = q_r;

endmodule

// ----- sv/drlm_eval.sv -----
// Two-stage compare unit: bounding box and overlap, then the two areas.
// Free running; both stages are registered. Uses drlm_pkg.
module drlm_eval (
  input  logic             clk,
  input  drlm_pkg::box_t   m,
  input  drlm_pkg::entry_t s,
  output drlm_pkg::eval_t  res
);
  import drlm_pkg::*;

  box_t   join_r;
  dim_t   jw_r, jh_r, cw_r, ch_r;
  area_t  sarea_r;
  eval_t  res_r;
  box_t   join_c;
  coord_t cx1, cy1, cx2, cy2;
  logic   ov;

  // Overlap corners of the two rectangles.
  always_comb begin
    join_c = box_join(m, s.box);
    cx1    = (m.x1 > s.box.x1) ? m.x1 : s.box.x1;
    cy1    = (m.y1 > s.box.y1) ? m.y1 : s.box.y1;
    cx2    = (m.x2 < s.box.x2) ? m.x2 : s.box.x2;
    cy2    = (m.y2 < s.box.y2) ? m.y2 : s.box.y2;
    ov     = (cx1 <= cx2) && (cy1 <= cy2);
  end

  // First stage: spans of the join and of the overlap.
  always_ff @(posedge clk) begin
    join_r  <= join_c;
    jw_r    <= span(join_c.x1, join_c.x2);
    jh_r    <= span(join_c.y1, join_c.y2);
    cw_r    <= ov ? span(cx1, cx2) : '0;
    ch_r    <= ov ? span(cy1, cy2) : '0;
    sarea_r <= s.area;
  end

  // Second stage: one multiplier each for the join and the overlap.
  always_ff @(posedge clk) begin
    res_r.jbox  <= join_r;
    res_r.jarea <= area_t'(jw_r) * area_t'(jh_r);
    res_r.com   <= area_t'(cw_r) * area_t'(ch_r);
    res_r.sarea <= sarea_r;
  end

  assign res = res_r;

endmodule

// ----- sv/dirty_rect_list_merger.sv -----
// Dirty rectangle list merger: an add passes each of the n stored entries through the
// shared compare unit in turn (load, multiply and decide steps per entry), and when a
// forced merge runs it passes the k entries left through it again, then drops one. A
// flush gives one entry a cycle while out_stall is low; one request is processed at a
// time. Synchronous active-low reset empties the list and sets capacity to 16.
// Top level: control sequencer over a chain of drlm_cell and one drlm_eval.
module dirty_rect_list_merger (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [drlm_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  drlm_pkg::coord_t           in_left_x,
  input  drlm_pkg::coord_t           in_top_y,
  input  drlm_pkg::coord_t           in_right_x,
  input  drlm_pkg::coord_t           in_bottom_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output drlm_pkg::coord_t           out_left_x,
  output drlm_pkg::coord_t           out_top_y,
  output drlm_pkg::coord_t           out_right_x,
  output drlm_pkg::coord_t           out_bottom_y,
  output logic                       out_is_entry,
  output logic [drlm_pkg::TOTAL_W-1:0] out_entry_total,
  output logic                       out_last
);
  import drlm_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_INIT   = 10'b0000000010,
    ST_LOAD   = 10'b0000000100,
    ST_MUL    = 10'b0000001000,
    ST_DEC    = 10'b0000010000,
    ST_CHECK  = 10'b0000100000,
    ST_DROP   = 10'b0001000000,
    ST_APPEND = 10'b0010000000,
    ST_REPORT = 10'b0100000000,
    ST_FLUSH  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  cnt_t   cnt_r, cnt_nxt, rem_r, rem_nxt, ftot_r, ftot_nxt, cap_eff;
  idx_t   idx_r, idx_nxt, bidx_r, bidx_nxt;
  box_t   m_r, m_nxt, bj_r, bj_nxt;
  area_t  am_r, am_nxt, bja_r, bja_nxt;
  sum_t   bg_r, bg_nxt, gain, rhs;
  logic   evict_r, evict_nxt, bv_r, bv_nxt, fit;
  logic   shift_en, wr_en;
  cnt_t   wr_idx;
  entry_t wr_data;
  entry_t cells [MAX_RECTS];
  eval_t  ev;
  logic   out_free;
  box_t   obox_r, obox_nxt;
  logic   ovalid_r, ovalid_nxt, oentry_r, oentry_nxt, olast_r, olast_nxt;
  cnt_t   ototal_r, ototal_nxt;

  // Effective capacity, clamped to 1..MAX_RECTS.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = cnt_t'(1);
    end else if (int'(cap_r) > MAX_RECTS) begin
      cap_eff = cnt_t'(MAX_RECTS);
    end else begin
      cap_eff = cnt_t'(cap_r);
    end
  end

  // Chain of storage cells; cell 0 is the head of the list.
  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    entry_t nb;
    if (i == MAX_RECTS - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cells[i+1];
    end
    drlm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .wr_en    (wr_en && (wr_idx == cnt_t'(i))),
      .nb_in    (nb),
      .wr_data  (wr_data),
      .q        (cells[i])
    );
  end

  // Shared compare unit, fed by the growing rectangle and the head entry.
  drlm_eval u_eval (
    .clk (clk),
    .m   (m_r),
    .s   (cells[0]),
    .res (ev)
  );

  // Exact-cover test and added area for the forced merge.
  always_comb begin
    rhs  = sum_t'(am_r) + sum_t'(ev.sarea) - sum_t'(ev.com);
    fit  = (sum_t'(ev.jarea) == rhs);
    gain = sum_t'(ev.jarea) + sum_t'(ev.com) - sum_t'(am_r) - sum_t'(ev.sarea);
  end

  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign wr_data  = (state_r == ST_APPEND) ? entry_t'{box: m_r, area: am_r} : cells[0];
  assign wr_idx   = (state_r == ST_APPEND) ? cnt_r : cnt_r - cnt_t'(1);

  // Sequencer: rotates the list through the head cell one entry per step.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    ftot_nxt   = ftot_r;
    idx_nxt    = idx_r;
    bidx_nxt   = bidx_r;
    m_nxt      = m_r;
    am_nxt     = am_r;
    bj_nxt     = bj_r;
    bja_nxt    = bja_r;
    bg_nxt     = bg_r;
    bv_nxt     = bv_r;
    evict_nxt  = evict_r;
    shift_en   = 1'b0;
    wr_en      = 1'b0;
    obox_nxt   = obox_r;
    oentry_nxt = oentry_r;
    olast_nxt  = olast_r;
    ototal_nxt = ototal_r;
    ovalid_nxt = ovalid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_FLUSH) begin
            rem_nxt   = cnt_r;
            ftot_nxt  = cnt_r;
            state_nxt = (cnt_r == '0) ? ST_REPORT : ST_FLUSH;
          end else begin
            m_nxt.x1  = (in_left_x < in_right_x) ? in_left_x : in_right_x;
            m_nxt.x2  = (in_left_x < in_right_x) ? in_right_x : in_left_x;
            m_nxt.y1  = (in_top_y < in_bottom_y) ? in_top_y : in_bottom_y;
            m_nxt.y2  = (in_top_y < in_bottom_y) ? in_bottom_y : in_top_y;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        am_nxt    = area_t'(span(m_r.x1, m_r.x2)) * area_t'(span(m_r.y1, m_r.y2));
        rem_nxt   = cnt_r;
        evict_nxt = 1'b0;
        state_nxt = (cnt_r == '0) ? ST_CHECK : ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        shift_en = 1'b1;
        rem_nxt  = rem_r - cnt_t'(1);
        if (!evict_r) begin
          // Absorb an entry that the join covers exactly, else keep it at the tail.
          if (fit) begin
            m_nxt   = ev.jbox;
            am_nxt  = ev.jarea;
            cnt_nxt = cnt_r - cnt_t'(1);
          end else begin
            wr_en = 1'b1;
          end
          state_nxt = (rem_r == cnt_t'(1)) ? ST_CHECK : ST_LOAD;
        end else begin
          // Track the entry of least added area; the first one wins a tie.
          wr_en = 1'b1;
          if (!bv_r || (gain < bg_r)) begin
            bv_nxt   = 1'b1;
            bg_nxt   = gain;
            bidx_nxt = idx_r;
            bj_nxt   = ev.jbox;
            bja_nxt  = ev.jarea;
          end
          idx_nxt = idx_r + idx_t'(1);
          if (rem_r == cnt_t'(1)) begin
            rem_nxt   = cnt_r;
            idx_nxt   = '0;
            state_nxt = ST_DROP;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_CHECK: begin
        if (cnt_r >= cap_eff) begin
          evict_nxt = 1'b1;
          bv_nxt    = 1'b0;
          rem_nxt   = cnt_r;
          idx_nxt   = '0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_DROP: begin
        // One more rotation that removes the chosen entry.
        shift_en = 1'b1;
        rem_nxt  = rem_r - cnt_t'(1);
        idx_nxt  = idx_r + idx_t'(1);
        if (idx_r == bidx_r) begin
          m_nxt   = bj_r;
          am_nxt  = bja_r;
          cnt_nxt = cnt_r - cnt_t'(1);
        end else begin
          wr_en = 1'b1;
        end
        state_nxt = (rem_r == cnt_t'(1)) ? ST_APPEND : ST_DROP;
      end
      ST_APPEND: begin
        wr_en     = 1'b1;
        cnt_nxt   = cnt_r + cnt_t'(1);
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obox_nxt   = '0;
          oentry_nxt = 1'b0;
          ototal_nxt = cnt_r;
          olast_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obox_nxt   = cells[0].box;
          oentry_nxt = 1'b1;
          ototal_nxt = ftot_r;
          olast_nxt  = (rem_r == cnt_t'(1));
          shift_en   = 1'b1;
          rem_nxt    = rem_r - cnt_t'(1);
          if (rem_r == cnt_t'(1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cap_r    <= CAP_W'(16);
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      evict_r  <= 1'b0;
      bv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      evict_r  <= evict_nxt;
      bv_r     <= bv_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    ftot_r   <= ftot_nxt;
    idx_r    <= idx_nxt;
    bidx_r   <= bidx_nxt;
    m_r      <= m_nxt;
    am_r     <= am_nxt;
    bj_r     <= bj_nxt;
    bja_r    <= bja_nxt;
    bg_r     <= bg_nxt;
    obox_r   <= obox_nxt;
    oentry_r <= oentry_nxt;
    olast_r  <= olast_nxt;
    ototal_r <= ototal_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_left_x      = obox_r.x1;
  assign out_top_y       = obox_r.y1;
  assign out_right_x     = obox_r.x2;
  assign out_bottom_y    = obox_r.y2;
  assign out_is_entry    = oentry_r;
  assign out_entry_total = TOTAL_W'(ototal_r);
  assign out_last        = olast_r;

  // The list never holds more than its storage.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_RECTS) else $error("entry count beyond storage");

  // An emitted entry always comes from a non-empty list.
  a_entry_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_entry) |-> (out_entry_total != '0))
    else $error("entry emitted with zero total");

  // An accepted request holds off the next one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("second request taken");

  // A compare step only starts with entries left to visit.
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (rem_r != '0)) else $error("compare on empty pass");

endmodule
